// ===== rtl/serial_unit_command_sequencer_unit_defines.svh =====
// Assertion macros for the filament unit link sequencer.
// No dependencies; included by the modules that check their own logic.
`ifndef SERIAL_UNIT_COMMAND_SEQUENCER_UNIT_DEFINES_SVH
`define SERIAL_UNIT_COMMAND_SEQUENCER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SUCS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SUCS_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SUCS_ASSERT(label, clk, rst_n, prop, msg)
`define SUCS_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ===== rtl/sucs_pkg.sv =====
// Shared types and constants of the filament unit link sequencer.
// No dependencies.
package sucs_pkg;

    localparam int SLOT_COUNT_DEF = 5;
    localparam int TAIL_DEPTH_DEF = 6;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_BYTE = 2'd1;
    localparam logic [1:0] OP_REQ  = 2'd2;

    localparam logic [2:0] CFG_POLL_INTERVAL = 3'd0;
    localparam logic [2:0] CFG_POLL_TIMEOUT  = 3'd1;
    localparam logic [2:0] CFG_CMD_TIMEOUT   = 3'd2;
    localparam logic [2:0] CFG_START_TIMEOUT = 3'd3;
    localparam logic [2:0] CFG_REQ_BUILD     = 3'd4;
    localparam logic [2:0] CFG_STEALTH       = 3'd5;

    localparam logic [3:0] PH_OFF     = 4'd0;
    localparam logic [3:0] PH_START   = 4'd1;
    localparam logic [3:0] PH_VERSION = 4'd2;
    localparam logic [3:0] PH_BUILD   = 4'd3;
    localparam logic [3:0] PH_MODE    = 4'd4;
    localparam logic [3:0] PH_SENSOR  = 4'd5;
    localparam logic [3:0] PH_IDLE    = 4'd6;
    localparam logic [3:0] PH_POLL    = 4'd7;
    localparam logic [3:0] PH_CMD     = 4'd8;

    localparam logic [2:0] K_T = 3'd0;
    localparam logic [2:0] K_L = 3'd1;
    localparam logic [2:0] K_C = 3'd2;
    localparam logic [2:0] K_U = 3'd3;
    localparam logic [2:0] K_E = 3'd4;
    localparam logic [2:0] K_R = 3'd5;

    // classified event from the front part
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] rx_byte;
        logic       req_ok;
        logic [2:0] kind;
        logic [2:0] slot;
    } event_t;

    typedef struct packed {
        logic [7:0]  tx_byte;
        logic        tx_valid;
        logic        last;
        logic [3:0]  link_state;
        logic        ready_res;
        logic        enabled;
        logic [7:0]  sensor_value;
        logic        version_fault;
        logic [15:0] unit_version;
    } result_t;

    function automatic logic [7:0] kind_letter(input logic [2:0] k);
        logic [7:0] l;
        begin
            case (k)
                K_T:     l = "T";
                K_L:     l = "L";
                K_C:     l = "C";
                K_U:     l = "U";
                K_E:     l = "E";
                default: l = "R";
            endcase
            return l;
        end
    endfunction

    function automatic logic is_slotted(input logic [2:0] k);
        return (k == K_T) || (k == K_L) || (k == K_E);
    endfunction

    function automatic logic same_sym(input logic [7:0] a, input logic [7:0] b);
        return (a == b) || (((a == 8'h0d) || (a == 8'h0a)) && ((b == 8'h0d) || (b == 8'h0a)));
    endfunction

endpackage

// ===== rtl/sucs_stream_if.sv =====
// Valid/ready channel carrying a payload of a given type.
// Depends on nothing but the type handed in.
interface sucs_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/sucs_in_t_pkg.sv =====
// Input item type of the filament unit link sequencer.
// Used by the top level and its test environment.
package sucs_in_pkg;
    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] rx_byte;
        logic [2:0] cmd_kind;
        logic [2:0] filament;
    } in_item_t;
endpackage

// ===== rtl/sucs_front.sv =====
// Front part: takes input items, validates requests, pushes events to the queue.
// Depends on sucs_pkg and sucs_in_pkg.
module sucs_front #(
    parameter int SLOT_COUNT = sucs_pkg::SLOT_COUNT_DEF
) (
    input  logic                   in_valid,
    output logic                   in_ready,
    input  sucs_in_pkg::in_item_t  in_item,
    output logic                   q_push,
    output sucs_pkg::event_t       q_data,
    input  logic                   q_full
);
    logic slotted;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;
    assign slotted  = sucs_pkg::is_slotted(in_item.cmd_kind);

    always_comb
    begin
        q_data.op      = in_item.opcode;
        q_data.rx_byte = in_item.rx_byte;
        q_data.kind    = in_item.cmd_kind;
        q_data.slot    = slotted ? in_item.filament : 3'd0;
        q_data.req_ok  = (in_item.cmd_kind <= sucs_pkg::K_R)
                      && (!slotted || (32'(in_item.filament) < 32'(SLOT_COUNT)));
    end
endmodule

// ===== rtl/sucs_queue.sv =====
// Short event queue between front and back parts.
// Depends on sucs_pkg and the defines header.
`include "serial_unit_command_sequencer_unit_defines.svh"
module sucs_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sucs_pkg::event_t push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output sucs_pkg::event_t head
);
    sucs_pkg::event_t mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign head      = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop) rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    `SUCS_ASSERT(a_no_overflow, clk, rst_n, push |-> !full, "queue overflow")
    `SUCS_ASSERT(a_no_underflow, clk, rst_n, pop |-> not_empty, "queue underflow")
    `SUCS_ASSERT(a_cnt_range, clk, rst_n, cnt_reg != 2'd3, "queue count out of range")
endmodule

// ===== rtl/sucs_back.sv =====
// Back part: link sequencer state, receive tail, parser, timers and result output.
// Depends on sucs_pkg and the defines header.
`include "serial_unit_command_sequencer_unit_defines.svh"
module sucs_back #(
    parameter int TAIL_DEPTH = sucs_pkg::TAIL_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              ev_avail,
    input  sucs_pkg::event_t  ev,
    output logic              ev_pop,
    input  logic [15:0]       poll_interval_ms,
    input  logic [15:0]       poll_timeout_ms,
    input  logic [17:0]       command_timeout_ms,
    input  logic [31:0]       start_timeout_ms,
    input  logic [15:0]       required_build,
    input  logic              stealth_mode,
    output logic              out_valid,
    input  logic              out_ready,
    output sucs_pkg::result_t out_item
);
    localparam int CW = $clog2(TAIL_DEPTH + 1);

    logic [3:0]  phase_reg;
    logic        pend_v_reg, retry_v_reg;
    logic [2:0]  pend_k_reg, pend_s_reg, retry_k_reg, retry_s_reg;
    logic [31:0] ms_rst_reg, ms_req_reg, ms_rsp_reg;
    logic [7:0]  tail_reg [TAIL_DEPTH];
    logic [CW-1:0] cnt_reg;
    logic [15:0] acc_reg;
    logic        open_reg;
    logic        ready_reg, en_reg, fault_reg;
    logic [7:0]  sensor_reg;
    logic [15:0] version_reg;

    // output: up to three bytes, held in a small holding register
    logic        busy_reg;
    logic [1:0]  idx_reg;
    logic        txv_reg;
    logic [7:0]  b0_reg, b1_reg;

    logic take;
    // updated values after the event side effects
    logic [31:0] rst1, req1, rsp1;
    logic [7:0]  tail1 [TAIL_DEPTH];
    logic [CW-1:0] cnt1;
    logic [15:0] acc1;
    logic        open1, pv1, ready1;
    logic [2:0]  pk1, ps1;
    logic [19:0] acc_x10;
    logic        m_ok, m_start;
    // next values
    logic [3:0]  phase_n;
    logic        pv_n, rv_n, ready_n, en_n, fault_n, snd;
    logic [2:0]  pk_n, ps_n, rk_n, rs_n;
    logic [31:0] req_n, rsp_n;
    logic [7:0]  sensor_n, let_n, dig_n;
    logic [15:0] version_n;
    logic [7:0]  sens_acc;

    assign take   = ev_avail && (!busy_reg || (out_ready && idx_reg == 2'd0));
    assign ev_pop = take;

    always_comb
    begin
        rst1 = ms_rst_reg;
        req1 = ms_req_reg;
        rsp1 = ms_rsp_reg;
        for (int i = 0; i < TAIL_DEPTH; i++) tail1[i] = tail_reg[i];
        cnt1 = cnt_reg;
        acc1 = acc_reg;
        open1 = open_reg;
        pv1 = pend_v_reg;
        pk1 = pend_k_reg;
        ps1 = pend_s_reg;
        ready1 = ready_reg;
        acc_x10 = {4'd0, acc_reg} * 20'd10 + {12'd0, ev.rx_byte - 8'h30};
        case (ev.op)
            sucs_pkg::OP_TICK:
            begin
                if (rst1 != '1) rst1 = rst1 + 32'd1;
                if (req1 != '1) req1 = req1 + 32'd1;
                if (rsp1 != '1) rsp1 = rsp1 + 32'd1;
            end
            sucs_pkg::OP_BYTE:
            begin
                for (int i = 0; i < TAIL_DEPTH - 1; i++) tail1[i] = tail_reg[i+1];
                tail1[TAIL_DEPTH-1] = ev.rx_byte;
                if (32'(cnt_reg) < TAIL_DEPTH) cnt1 = cnt_reg + CW'(1);
                if (open_reg)
                begin
                    if (ev.rx_byte >= 8'h30 && ev.rx_byte <= 8'h39)
                        acc1 = (acc_x10 > 20'd65535) ? 16'hffff : acc_x10[15:0];
                    else
                        open1 = 1'b0;
                end
            end
            sucs_pkg::OP_REQ:
            begin
                if (ev.req_ok)
                begin
                    pv1 = 1'b1;
                    pk1 = ev.kind;
                    ps1 = ev.slot;
                    ready1 = 1'b0;
                end
            end
            default: ;
        endcase
        m_ok = (32'(cnt1) >= 3) && sucs_pkg::same_sym(tail1[TAIL_DEPTH-3], "o")
            && sucs_pkg::same_sym(tail1[TAIL_DEPTH-2], "k")
            && sucs_pkg::same_sym(tail1[TAIL_DEPTH-1], 8'h0a);
        m_start = (32'(cnt1) >= 6) && sucs_pkg::same_sym(tail1[TAIL_DEPTH-6], "s")
            && sucs_pkg::same_sym(tail1[TAIL_DEPTH-5], "t")
            && sucs_pkg::same_sym(tail1[TAIL_DEPTH-4], "a")
            && sucs_pkg::same_sym(tail1[TAIL_DEPTH-3], "r")
            && sucs_pkg::same_sym(tail1[TAIL_DEPTH-2], "t")
            && sucs_pkg::same_sym(tail1[TAIL_DEPTH-1], 8'h0a);
        sens_acc = (acc1 > 16'd255) ? 8'hff : acc1[7:0];
    end

    always_comb
    begin
        phase_n = phase_reg;
        pv_n = pv1; pk_n = pk1; ps_n = ps1;
        rv_n = retry_v_reg; rk_n = retry_k_reg; rs_n = retry_s_reg;
        ready_n = ready1; en_n = en_reg; fault_n = fault_reg;
        req_n = req1; rsp_n = rsp1;
        sensor_n = sensor_reg; version_n = version_reg;
        snd = 1'b0; let_n = "P"; dig_n = "0";
        case (phase_reg)
            sucs_pkg::PH_START:
                if (m_start)
                begin
                    rsp_n = '0; snd = 1'b1; let_n = "S"; dig_n = "1";
                    phase_n = sucs_pkg::PH_VERSION;
                end
                else if (rst1 > start_timeout_ms) phase_n = sucs_pkg::PH_OFF;
            sucs_pkg::PH_VERSION:
                if (m_ok)
                begin
                    rsp_n = '0; version_n = acc1; snd = 1'b1; let_n = "S"; dig_n = "2";
                    phase_n = sucs_pkg::PH_BUILD;
                end
            sucs_pkg::PH_BUILD:
                if (m_ok)
                begin
                    rsp_n = '0;
                    if (acc1 < required_build)
                    begin
                        fault_n = 1'b1; phase_n = sucs_pkg::PH_OFF;
                    end
                    else if (stealth_mode)
                    begin
                        snd = 1'b1; let_n = "M"; dig_n = "1"; phase_n = sucs_pkg::PH_MODE;
                    end
                    else
                    begin
                        snd = 1'b1; phase_n = sucs_pkg::PH_SENSOR;
                    end
                end
            sucs_pkg::PH_MODE:
                if (m_ok)
                begin
                    rsp_n = '0; snd = 1'b1; phase_n = sucs_pkg::PH_SENSOR;
                end
            sucs_pkg::PH_SENSOR:
                if (m_ok)
                begin
                    rsp_n = '0; sensor_n = sens_acc; en_n = 1'b1;
                    phase_n = sucs_pkg::PH_IDLE;
                end
            sucs_pkg::PH_IDLE:
                if (pv1)
                begin
                    snd = 1'b1; let_n = sucs_pkg::kind_letter(pk1);
                    dig_n = sucs_pkg::is_slotted(pk1) ? (8'h30 + {5'd0, ps1}) : "0";
                    rv_n = 1'b1; rk_n = pk1; rs_n = ps1; pv_n = 1'b0;
                    phase_n = sucs_pkg::PH_CMD;
                end
                else if (rsp1 > {16'd0, poll_interval_ms})
                begin
                    snd = 1'b1; phase_n = sucs_pkg::PH_POLL;
                end
            sucs_pkg::PH_POLL:
                if (m_ok)
                begin
                    rsp_n = '0; sensor_n = sens_acc; phase_n = sucs_pkg::PH_IDLE;
                    if (!pv1) ready_n = 1'b1;
                end
                else if (req1 > {16'd0, poll_timeout_ms}) phase_n = sucs_pkg::PH_IDLE;
            sucs_pkg::PH_CMD:
                if (m_ok)
                begin
                    rsp_n = '0; ready_n = 1'b1; rv_n = 1'b0; phase_n = sucs_pkg::PH_IDLE;
                end
                else if (req1 > {14'd0, command_timeout_ms})
                begin
                    if (retry_v_reg)
                    begin
                        pv_n = 1'b1; pk_n = retry_k_reg; ps_n = retry_s_reg; rv_n = 1'b0;
                    end
                    phase_n = sucs_pkg::PH_IDLE;
                end
            default: ;
        endcase
        if (snd) req_n = '0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            for (int i = 0; i < TAIL_DEPTH; i++) tail_reg[i] <= snd ? 8'd0 : tail1[i];
            b0_reg <= let_n;
            b1_reg <= dig_n;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= sucs_pkg::PH_START;
            pend_v_reg <= 1'b0; pend_k_reg <= '0; pend_s_reg <= '0;
            retry_v_reg <= 1'b0; retry_k_reg <= '0; retry_s_reg <= '0;
            ms_rst_reg <= '0; ms_req_reg <= '0; ms_rsp_reg <= '0;
            cnt_reg <= '0; acc_reg <= '0; open_reg <= 1'b1;
            ready_reg <= 1'b0; en_reg <= 1'b0; fault_reg <= 1'b0;
            sensor_reg <= '0; version_reg <= '0;
            busy_reg <= 1'b0; idx_reg <= '0; txv_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                phase_reg <= phase_n;
                pend_v_reg <= pv_n; pend_k_reg <= pk_n; pend_s_reg <= ps_n;
                retry_v_reg <= rv_n; retry_k_reg <= rk_n; retry_s_reg <= rs_n;
                ms_rst_reg <= rst1; ms_req_reg <= req_n; ms_rsp_reg <= rsp_n;
                cnt_reg <= snd ? '0 : cnt1;
                acc_reg <= snd ? '0 : acc1;
                open_reg <= snd ? 1'b1 : open1;
                ready_reg <= ready_n; en_reg <= en_n; fault_reg <= fault_n;
                sensor_reg <= sensor_n; version_reg <= version_n;
                busy_reg <= 1'b1;
                txv_reg <= snd;
                idx_reg <= snd ? 2'd2 : 2'd0;
            end
            else if (busy_reg && out_ready)
            begin
                // advance through the pending bytes, last one frees the slot
                if (idx_reg == 2'd0) busy_reg <= 1'b0;
                else idx_reg <= idx_reg - 2'd1;
            end
        end
    end

    assign out_valid = busy_reg;
    always_comb
    begin
        out_item.tx_valid = txv_reg;
        out_item.last = (idx_reg == 2'd0);
        case (idx_reg)
            2'd2:    out_item.tx_byte = b0_reg;
            2'd1:    out_item.tx_byte = b1_reg;
            default: out_item.tx_byte = txv_reg ? 8'h0a : 8'h00;
        endcase
        out_item.link_state = phase_reg;
        out_item.ready_res = ready_reg;
        out_item.enabled = en_reg;
        out_item.sensor_value = sensor_reg;
        out_item.version_fault = fault_reg;
        out_item.unit_version = version_reg;
    end

    `SUCS_ASSERT(a_idx_only_tx, clk, rst_n, (idx_reg != 2'd0) |-> txv_reg, "multi-byte result without transmission")
    `SUCS_ASSERT(a_fault_off, clk, rst_n, fault_reg |-> (phase_reg == sucs_pkg::PH_OFF), "fault outside off phase")
    `SUCS_ASSERT(a_no_take_midframe, clk, rst_n, (busy_reg && idx_reg != 2'd0) |-> !take, "event taken mid transmission")
endmodule

// ===== rtl/serial_unit_command_sequencer_unit.sv =====
// Top level of the filament unit link sequencer: config registers, front, queue, back.
// Depends on sucs_pkg, sucs_in_pkg, sucs_stream_if and the sucs_* modules.
// Each item's results leave one per cycle while the receiver is ready, from an output
// register: one result for a plain event, three (letter, digit, line feed) for a
// transmission. The output byte sequencer takes the next item as the last result
// of the previous one leaves. A two-entry queue lets input keep flowing meanwhile.
module serial_unit_command_sequencer_unit #(
    parameter int SLOT_COUNT = sucs_pkg::SLOT_COUNT_DEF,
    parameter int TAIL_DEPTH = sucs_pkg::TAIL_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    sucs_stream_if.sink   in_ch,
    sucs_stream_if.source out_ch,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    logic [15:0] poll_interval_reg, poll_timeout_reg, required_build_reg;
    logic [17:0] cmd_timeout_reg;
    logic [31:0] start_timeout_reg;
    logic        stealth_reg;
    logic q_push, q_full, q_pop, q_ne;
    sucs_pkg::event_t q_in, q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_interval_reg <= 16'd300;
            poll_timeout_reg <= 16'd3000;
            cmd_timeout_reg <= 18'd60000;
            start_timeout_reg <= 32'd3000000;
            required_build_reg <= 16'd126;
            stealth_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sucs_pkg::CFG_POLL_INTERVAL: poll_interval_reg <= cfg_data[15:0];
                sucs_pkg::CFG_POLL_TIMEOUT:  poll_timeout_reg <= cfg_data[15:0];
                sucs_pkg::CFG_CMD_TIMEOUT:   cmd_timeout_reg <= cfg_data[17:0];
                sucs_pkg::CFG_START_TIMEOUT: start_timeout_reg <= cfg_data;
                sucs_pkg::CFG_REQ_BUILD:     required_build_reg <= cfg_data[15:0];
                sucs_pkg::CFG_STEALTH:       stealth_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    sucs_front #(.SLOT_COUNT(SLOT_COUNT)) u_front (
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .in_item(in_ch.payload), .q_push(q_push), .q_data(q_in), .q_full(q_full));

    sucs_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_in), .full(q_full),
        .pop(q_pop), .not_empty(q_ne), .head(q_head));

    sucs_back #(.TAIL_DEPTH(TAIL_DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n), .ev_avail(q_ne), .ev(q_head), .ev_pop(q_pop),
        .poll_interval_ms(poll_interval_reg), .poll_timeout_ms(poll_timeout_reg),
        .command_timeout_ms(cmd_timeout_reg), .start_timeout_ms(start_timeout_reg),
        .required_build(required_build_reg), .stealth_mode(stealth_reg),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_item(out_ch.payload));
endmodule

// ===== tb/sv/tb.sv =====
// Testbench for the filament unit link sequencer: random and directed events,
// checked against a cycle-free model of the protocol. Depends on sucs_pkg,
// sucs_in_pkg, sucs_stream_if and serial_unit_command_sequencer_unit.
`timescale 1ns / 1ps

module tb;
    import sucs_pkg::*;
    import sucs_in_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int SLOTS = 5;
    localparam int DEPTH = 6;
    localparam int CYCLE_LIMIT = 600000;

    // Protocol model plus the queue of results still owed by the block.
    class link_model;
        logic [31:0] poll_ivl, poll_tmo, cmd_tmo, start_tmo, req_build;
        logic stealth;
        logic [3:0] phase;
        logic pend_v, rty_v;
        logic [2:0] pend_k, pend_s, rty_k, rty_s;
        logic [31:0] t_reset, t_req, t_resp;
        logic [7:0] tail [DEPTH];
        int tail_n;
        logic [31:0] num;
        logic num_open;
        logic [31:0] build;
        logic rdy, en, fault;
        logic [7:0] sensor;
        logic [15:0] version;
        logic [7:0] tx [3];
        int tx_n;
        result_t due_results [$];
        int errors;

        function new();
            poll_ivl = 300; poll_tmo = 3000; cmd_tmo = 60000;
            start_tmo = 3000000; req_build = 126; stealth = 0;
            phase = PH_START;
            pend_v = 0; pend_k = '0; pend_s = '0;
            rty_v = 0; rty_k = '0; rty_s = '0;
            t_reset = 0; t_req = 0; t_resp = 0;
            foreach (tail[i]) tail[i] = '0;
            tail_n = 0; num = 0; num_open = 1; build = 0;
            rdy = 0; en = 0; fault = 0; sensor = '0; version = '0;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] d);
            case (idx)
                CFG_POLL_INTERVAL: poll_ivl = 32'(d[15:0]);
                CFG_POLL_TIMEOUT:  poll_tmo = 32'(d[15:0]);
                CFG_CMD_TIMEOUT:   cmd_tmo = 32'(d[17:0]);
                CFG_START_TIMEOUT: start_tmo = d;
                CFG_REQ_BUILD:     req_build = 32'(d[15:0]);
                CFG_STEALTH:       stealth = d[0];
                default: ;
            endcase
        endfunction

        function bit sym_eq(logic [7:0] a, logic [7:0] b);
            return (a == b) || ((a == 8'h0d || a == 8'h0a) && (b == 8'h0d || b == 8'h0a));
        endfunction

        function bit ends_ok();
            if (tail_n < 3) return 0;
            if (sym_eq(tail[DEPTH-3], "o") && sym_eq(tail[DEPTH-2], "k")
                && sym_eq(tail[DEPTH-1], 8'h0a))
            begin
                t_resp = 0;
                return 1;
            end
            return 0;
        endfunction

        function bit ends_start();
            logic [7:0] pat [6];
            pat = '{"s", "t", "a", "r", "t", 8'h0a};
            if (tail_n < 6) return 0;
            for (int k = 0; k < 6; k++)
                if (!sym_eq(tail[k], pat[k])) return 0;
            return 1;
        endfunction

        function void transmit(logic [7:0] letter, logic [7:0] digit);
            tx[0] = letter; tx[1] = digit; tx[2] = 8'h0a; tx_n = 3;
            foreach (tail[i]) tail[i] = '0;
            tail_n = 0; num = 0; num_open = 1; t_req = 0;
        endfunction

        function logic [7:0] sensor_of();
            return (num > 255) ? 8'd255 : num[7:0];
        endfunction

        function logic [31:0] sat_inc(logic [31:0] v);
            return (v == 32'hffff_ffff) ? v : v + 32'd1;
        endfunction

        function void advance();
            logic [7:0] d;
            case (phase)
                PH_START:
                    if (ends_start())
                    begin
                        t_resp = 0; transmit("S", "1"); phase = PH_VERSION;
                    end
                    else if (t_reset > start_tmo) phase = PH_OFF;
                PH_VERSION:
                    if (ends_ok())
                    begin
                        version = num[15:0]; transmit("S", "2"); phase = PH_BUILD;
                    end
                PH_BUILD:
                    if (ends_ok())
                    begin
                        build = num;
                        if (build < req_build)
                        begin
                            fault = 1; phase = PH_OFF;
                        end
                        else if (stealth)
                        begin
                            transmit("M", "1"); phase = PH_MODE;
                        end
                        else
                        begin
                            transmit("P", "0"); phase = PH_SENSOR;
                        end
                    end
                PH_MODE:
                    if (ends_ok())
                    begin
                        transmit("P", "0"); phase = PH_SENSOR;
                    end
                PH_SENSOR:
                    if (ends_ok())
                    begin
                        sensor = sensor_of(); en = 1; phase = PH_IDLE;
                    end
                PH_IDLE:
                    if (pend_v)
                    begin
                        d = (pend_k == K_T || pend_k == K_L || pend_k == K_E)
                            ? 8'h30 + {5'd0, pend_s} : "0";
                        transmit(kind_letter(pend_k), d);
                        rty_v = 1; rty_k = pend_k; rty_s = pend_s;
                        pend_v = 0; phase = PH_CMD;
                    end
                    else if (t_resp > poll_ivl)
                    begin
                        transmit("P", "0"); phase = PH_POLL;
                    end
                PH_POLL:
                    if (ends_ok())
                    begin
                        sensor = sensor_of(); phase = PH_IDLE;
                        if (!pend_v) rdy = 1;
                    end
                    else if (t_req > poll_tmo) phase = PH_IDLE;
                PH_CMD:
                    if (ends_ok())
                    begin
                        rdy = 1; rty_v = 0; phase = PH_IDLE;
                    end
                    else if (t_req > cmd_tmo)
                    begin
                        if (rty_v)
                        begin
                            pend_v = 1; pend_k = rty_k; pend_s = rty_s; rty_v = 0;
                        end
                        phase = PH_IDLE;
                    end
                default: ;
            endcase
        endfunction

        function void take_event(in_item_t it);
            logic [31:0] v;
            bit slotted;
            result_t r;
            int n;
            tx_n = 0;
            case (it.opcode)
                OP_TICK:
                begin
                    t_reset = sat_inc(t_reset);
                    t_req = sat_inc(t_req);
                    t_resp = sat_inc(t_resp);
                end
                OP_BYTE:
                begin
                    for (int i = 0; i < DEPTH - 1; i++) tail[i] = tail[i+1];
                    tail[DEPTH-1] = it.rx_byte;
                    if (tail_n < DEPTH) tail_n++;
                    if (num_open)
                    begin
                        if (it.rx_byte >= "0" && it.rx_byte <= "9")
                        begin
                            v = num * 32'd10 + 32'(it.rx_byte - 8'h30);
                            num = (v > 65535) ? 32'd65535 : v;
                        end
                        else num_open = 0;
                    end
                end
                OP_REQ:
                begin
                    slotted = (it.cmd_kind == K_T || it.cmd_kind == K_L
                               || it.cmd_kind == K_E);
                    if (it.cmd_kind <= K_R && (!slotted || 32'(it.filament) < SLOTS))
                    begin
                        pend_v = 1; pend_k = it.cmd_kind;
                        pend_s = slotted ? it.filament : 3'd0;
                        rdy = 0;
                    end
                end
                default: ;
            endcase
            advance();
            n = (tx_n > 0) ? tx_n : 1;
            for (int k = 0; k < n; k++)
            begin
                r.tx_byte = (tx_n > 0) ? tx[k] : 8'd0;
                r.tx_valid = (tx_n > 0);
                r.last = (k == n - 1);
                r.link_state = phase;
                r.ready_res = rdy;
                r.enabled = en;
                r.sensor_value = sensor;
                r.version_fault = fault;
                r.unit_version = version;
                due_results.push_back(r);
            end
        endfunction

        function void check_result(result_t got);
            result_t e;
            if (due_results.size() == 0)
            begin
                $error("unexpected transfer: tx_byte %0h", got.tx_byte);
                errors++;
                return;
            end
            e = due_results.pop_front();
            if (got.tx_byte !== e.tx_byte)
                begin $error("tx_byte exp %0h got %0h", e.tx_byte, got.tx_byte); errors++; end
            if (got.tx_valid !== e.tx_valid)
                begin $error("tx_valid exp %0d got %0d", e.tx_valid, got.tx_valid); errors++; end
            if (got.last !== e.last)
                begin $error("last exp %0d got %0d", e.last, got.last); errors++; end
            if (got.link_state !== e.link_state)
                begin
                    $error("link_state exp %0d got %0d", e.link_state, got.link_state);
                    errors++;
                end
            if (got.ready_res !== e.ready_res)
                begin $error("ready_res exp %0d got %0d", e.ready_res, got.ready_res); errors++; end
            if (got.enabled !== e.enabled)
                begin $error("enabled exp %0d got %0d", e.enabled, got.enabled); errors++; end
            if (got.sensor_value !== e.sensor_value)
                begin
                    $error("sensor_value exp %0d got %0d", e.sensor_value, got.sensor_value);
                    errors++;
                end
            if (got.version_fault !== e.version_fault)
                begin
                    $error("version_fault exp %0d got %0d", e.version_fault, got.version_fault);
                    errors++;
                end
            if (got.unit_version !== e.unit_version)
                begin
                    $error("unit_version exp %0d got %0d", e.unit_version, got.unit_version);
                    errors++;
                end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [31:0] cfg_data;

    sucs_stream_if #(.payload_t(in_item_t)) in_if ();
    sucs_stream_if #(.payload_t(result_t)) out_if ();

    serial_unit_command_sequencer_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_if.sink),
        .out_ch    (out_if.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    link_model model;
    int burst_left;
    int sent;
    int cycles;
    int stall_tick;

    always
    begin
        clk = 1'b1; #2;
        clk = 1'b0; #2;
    end

    // Receiver: free-running stretches alternate with a patterned, random stall.
    always @(negedge clk)
    begin
        stall_tick <= stall_tick + 1;
        if (stall_tick[7:6] == 2'd0)
            out_if.ready <= 1'b1;
        else
            out_if.ready <= (stall_tick % 5 != 2) && ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_if.valid && out_if.ready)
            model.check_result(out_if.payload);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic drive_event(logic [1:0] op, logic [7:0] b, logic [2:0] k, logic [2:0] f);
        in_item_t it;
        it.opcode = op; it.rx_byte = b; it.cmd_kind = k; it.filament = f;
        @(negedge clk);
        in_if.valid <= 1'b1;
        in_if.payload <= it;
        do @(posedge clk); while (!in_if.ready);
        model.take_event(it);
        sent++;
        if (burst_left == 0)
        begin
            @(negedge clk);
            in_if.valid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
            burst_left = int'($urandom_range(0, 12));
        end
        else
            burst_left--;
    endtask

    task automatic tick();
        drive_event(OP_TICK, 8'($urandom), 3'($urandom), 3'($urandom));
    endtask

    task automatic rx_string(string s);
        for (int i = 0; i < s.len(); i++)
            drive_event(OP_BYTE, s[i], 3'($urandom), 3'($urandom));
    endtask

    // Answer from the unit: a few leading digits, then ok and a line end.
    task automatic rx_answer();
        repeat ($urandom_range(0, 3))
            drive_event(OP_BYTE, 8'("0" + $urandom_range(0, 9)), 3'd0, 3'd0);
        rx_string("ok");
        drive_event(OP_BYTE, $urandom_range(0, 1) ? 8'h0a : 8'h0d, 3'd0, 3'd0);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] d);
        @(negedge clk);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= d;
        @(negedge clk);
        cfg_we <= 1'b0;
        model.set_reg(idx, d);
    endtask

    task automatic drain();
        @(negedge clk);
        in_if.valid <= 1'b0;
        while (model.due_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic random_events(int count);
        int stop_at;
        int r;
        stop_at = sent + count;
        while (sent < stop_at)
        begin
            r = int'($urandom_range(0, 99));
            if (r < 30) tick();
            else if (r < 58) rx_answer();
            else if (r < 72)
                drive_event(OP_REQ, 8'($urandom), 3'($urandom), 3'($urandom));
            else if (r < 80)
                drive_event(OP_REQ, 8'($urandom), 3'($urandom_range(0, 5)),
                            3'($urandom_range(0, 4)));
            else if (r < 88)
                drive_event(OP_BYTE, 8'($urandom), 3'($urandom), 3'($urandom));
            else if (r < 92)
                drive_event(OP_NONE, 8'($urandom), 3'($urandom), 3'($urandom));
            else repeat ($urandom_range(5, 14)) tick();
        end
    endtask

    initial
    begin
        model = new();
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        in_if.valid = 1'b0; in_if.payload = '0;
        out_if.ready = 1'b0;
        burst_left = 0; sent = 0; cycles = 0; stall_tick = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_reg(CFG_POLL_INTERVAL, 32'd4);
        write_reg(CFG_POLL_TIMEOUT, 32'd6);
        write_reg(CFG_CMD_TIMEOUT, 32'd9);
        write_reg(CFG_START_TIMEOUT, 32'hffff_ffff);
        write_reg(CFG_REQ_BUILD, 32'd126);
        write_reg(CFG_STEALTH, 32'd1);
        write_reg(3'd7, 32'hffff_ffff);

        // Handshake with stealth mode, an early request and saturating numbers.
        tick();
        drive_event(OP_REQ, 8'hff, K_L, 3'd4);
        drive_event(OP_NONE, 8'h00, 3'd7, 3'd7);
        rx_string("start");
        drive_event(OP_BYTE, 8'h0d, 3'd0, 3'd0);
        rx_string("99999ok");
        drive_event(OP_BYTE, 8'h0a, 3'd0, 3'd0);
        rx_string("132ok\n");
        rx_string("ok\n");
        rx_string("300ok\n");
        tick();
        drive_event(OP_REQ, 8'd0, 3'd6, 3'd0);
        drive_event(OP_REQ, 8'd0, K_E, 3'd5);
        drain();

        random_events(180);
        drain();

        write_reg(CFG_POLL_INTERVAL, 32'd1);
        write_reg(CFG_POLL_TIMEOUT, 32'd65535);
        write_reg(CFG_CMD_TIMEOUT, 32'd1);
        write_reg(CFG_REQ_BUILD, 32'd0);
        write_reg(CFG_STEALTH, 32'd0);
        random_events(140);
        drain();

        write_reg(CFG_POLL_INTERVAL, 32'd65535);
        write_reg(CFG_POLL_TIMEOUT, 32'd1);
        write_reg(CFG_CMD_TIMEOUT, 32'd262143);
        write_reg(CFG_START_TIMEOUT, 32'd1);
        write_reg(CFG_REQ_BUILD, 32'd65535);
        random_events(60);
        drain();

        if (model.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
